// ===== rtl/pcxrle_pkg.sv =====
// ----------------------------------------------------------------------------
// pcxrle_pkg
// constants and types shared by the pcx run-length line encoder
// ----------------------------------------------------------------------------
`default_nettype none

package pcxrle_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned RunW    = 6;
  localparam int unsigned SlotNum = 4;
  localparam int unsigned SlotW   = $clog2(SlotNum);
  localparam int unsigned CountW  = $clog2(SlotNum + 1);

  localparam logic [RunW-1:0]  RunCut     = 6'h3f;
  localparam logic [ByteW-1:0] PrefixMark = 8'hc0;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [RunW-1:0]  run_t;

  // prefix needed when the count exceeds one or the inverted byte has both top bits set
  function automatic logic needs_prefix(input byte_t inv, input run_t count);
    needs_prefix = ((inv & PrefixMark) == PrefixMark) || (count > run_t'(1));
  endfunction

  function automatic byte_t prefix_byte(input run_t count);
    prefix_byte = PrefixMark | {{(ByteW - RunW){1'b0}}, count};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pcx_rle_line_encoder.sv =====
// ----------------------------------------------------------------------------
// pcx_rle_line_encoder
// pcx run-length encoder for one scan line of raster bytes per frame
// ----------------------------------------------------------------------------
//  channel   dir  data                      flags
//  s_*       in   tdata[7:0] pixel_byte     tlast line_end
//  m_*       out  tdata[7:0] code_byte      tlast item_last, tuser line_done
//
//  a request that emits no code byte is taken back to back
//  a request that emits k code bytes (1 to 4) holds the input until they drain:
//  the one-byte output port drains a four-slot result register
//  the next request is taken in the cycle the last pending byte leaves
//  reset clears the run state and the result count (not the slot bytes), no clearing pass
//  output stalls hold m_tdata and flags and back up into s_tready
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_line_encoder (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire pcxrle_pkg::byte_t       s_tdata,   // [7:0] pixel_byte
  input  wire logic                    s_tlast,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output pcxrle_pkg::byte_t            m_tdata,   // [7:0] code_byte
  output logic                         m_tlast,
  output logic                         m_tuser    // [0] line_done
);

  import pcxrle_pkg::*;

  byte_t held_byte;
  run_t  run_length;
  logic  line_active;

  byte_t             slot_byte [SlotNum];
  byte_t             slot_byte_next [SlotNum];
  logic [CountW-1:0] remain;
  logic [CountW-1:0] emit_count;
  logic [SlotW-1:0]  rd_ptr;
  logic              line_flag;

  byte_t held_next;
  run_t  run_next;
  run_t  run_inc;
  logic  active_next;

  byte_t a_byte, b_byte, a_inv, b_inv;
  run_t  a_count, b_count;
  logic  a_en, b_en;

  byte_t            cand_byte [SlotNum];
  logic             cand_en [SlotNum];
  logic [SlotW-1:0] cand_pos [SlotNum];

  logic s_acc, m_acc;

  assign s_tready = (remain == '0) || ((remain == CountW'(1)) && m_tready);
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;

  assign m_tvalid = (remain != '0);
  assign m_tdata  = slot_byte[rd_ptr];
  assign m_tlast  = (remain == CountW'(1));
  assign m_tuser  = m_tlast && line_flag;

  // run bookkeeping for the incoming byte
  always_comb begin
    held_next   = held_byte;
    run_next    = run_length;
    active_next = line_active;
    run_inc     = run_length + run_t'(1);
    a_en        = 1'b0;
    a_byte      = held_byte;
    a_count     = run_length;
    b_en        = 1'b0;
    if (!line_active) begin
      held_next   = s_tdata;
      run_next    = run_t'(1);
      active_next = 1'b1;
    end else if (s_tdata == held_byte) begin
      if (run_inc == RunCut) begin
        a_en     = 1'b1;
        a_count  = RunCut;
        run_next = '0;
      end else begin
        run_next = run_inc;
      end
    end else begin
      a_en      = (run_length != '0);
      held_next = s_tdata;
      run_next  = run_t'(1);
    end
    b_byte  = held_next;
    b_count = run_next;
    if (s_tlast) begin
      b_en        = (run_next != '0);
      run_next    = '0;
      active_next = 1'b0;
    end
  end

  assign a_inv = ~a_byte;
  assign b_inv = ~b_byte;

  // candidate code bytes in order, then packed into the slots
  always_comb begin
    cand_byte[0] = prefix_byte(a_count);
    cand_en[0]   = a_en && needs_prefix(a_inv, a_count);
    cand_byte[1] = a_inv;
    cand_en[1]   = a_en;
    cand_byte[2] = prefix_byte(b_count);
    cand_en[2]   = b_en && needs_prefix(b_inv, b_count);
    cand_byte[3] = b_inv;
    cand_en[3]   = b_en;
  end

  always_comb begin
    cand_pos[0] = '0;
    for (int i = 1; i < SlotNum; i++) begin
      cand_pos[i] = cand_pos[i-1] + SlotW'(cand_en[i-1]);
    end
    emit_count = CountW'(cand_pos[SlotNum-1]) + CountW'(cand_en[SlotNum-1]);
    for (int i = 0; i < SlotNum; i++) begin
      slot_byte_next[i] = slot_byte[i];
    end
    for (int i = 0; i < SlotNum; i++) begin
      if (cand_en[i]) begin
        slot_byte_next[cand_pos[i]] = cand_byte[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte   <= '0;
      run_length  <= '0;
      line_active <= 1'b0;
      remain      <= '0;
      rd_ptr      <= '0;
      line_flag   <= 1'b0;
    end else begin
      if (s_acc) begin
        held_byte   <= held_next;
        run_length  <= run_next;
        line_active <= active_next;
        remain      <= emit_count;
        rd_ptr      <= '0;
        line_flag   <= s_tlast;
      end else if (m_acc) begin
        remain <= remain - CountW'(1);
        rd_ptr <= rd_ptr + SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      for (int i = 0; i < SlotNum; i++) begin
        slot_byte[i] <= slot_byte_next[i];
      end
    end
  end

  a_remain_range: assert property (@(posedge clk) disable iff (rst)
    remain <= CountW'(SlotNum))
    else $error("result count out of range");

  a_line_end_emits: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tlast |=> m_tvalid)
    else $error("line end produced no code byte");

  a_line_closes: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tlast |=> !line_active && (run_length == '0))
    else $error("line still open after line end");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("line done away from final byte");

  a_run_below_cut: assert property (@(posedge clk) disable iff (rst)
    run_length != RunCut)
    else $error("open run reached the cut length");

endmodule

`default_nettype wire
